// File: hw/rtl/reload_down_counter_timer_unit_macros.svh
// Assertion macros for the reload down-counter timer.
// Clock clk_i and reset rst_ni must be visible where the macros are used.
`ifndef RELOAD_DOWN_COUNTER_TIMER_UNIT_MACROS_SVH
`define RELOAD_DOWN_COUNTER_TIMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check a property while out of reset
`define RDCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check a property at every edge, reset included
`define RDCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RDCT_ASSERT(lbl, prop, msg)
`define RDCT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hw/rtl/rdct_pkg.sv
// Shared types and codes for the reload down-counter timer.
// No dependencies; used by the channel interfaces and the top level.
package rdct_pkg;

  localparam int unsigned COUNTER_WIDTH = 24;  // 8 .. 32
  localparam int unsigned DATA_WIDTH    = 32;
  localparam int unsigned PRESC_WIDTH   = 3;

  typedef logic [COUNTER_WIDTH-1:0] count_t;
  typedef logic [DATA_WIDTH-1:0]    data_t;
  typedef logic [PRESC_WIDTH-1:0]   presc_t;
  typedef logic [1:0]               action_t;
  typedef logic [1:0]               reg_idx_t;

  // action codes
  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_READ  = 2'd1;
  localparam action_t ACT_WRITE = 2'd2;

  // register indexes
  localparam reg_idx_t REG_CTRL    = 2'd0;
  localparam reg_idx_t REG_RELOAD  = 2'd1;
  localparam reg_idx_t REG_CURRENT = 2'd2;
  localparam reg_idx_t REG_ELAPSED = 2'd3;

  // control register bit positions
  localparam int unsigned CTRL_ENABLE_BIT   = 0;
  localparam int unsigned CTRL_IRQ_EN_BIT   = 1;
  localparam int unsigned CTRL_CORE_CLK_BIT = 2;
  localparam int unsigned CTRL_ONE_SHOT_BIT = 3;
  localparam int unsigned CTRL_FLAG_BIT     = 16;

endpackage

// File: hw/rtl/rdct_if.sv
// Valid/ready channel interfaces for the timer's request and result items.
// Depends on rdct_pkg for payload types.
interface rdct_in_if;
  import rdct_pkg::*;

  logic     valid;
  logic     ready;
  action_t  action;
  reg_idx_t reg_index;
  data_t    write_data;

  modport source (output valid, action, reg_index, write_data, input ready);
  modport sink   (input valid, action, reg_index, write_data, output ready);
endinterface

interface rdct_out_if;
  import rdct_pkg::*;

  logic  valid;
  logic  ready;
  data_t read_data;
  logic  interrupt_request;

  modport source (output valid, read_data, interrupt_request, input ready);
  modport sink   (input valid, read_data, interrupt_request, output ready);
endinterface

// File: hw/rtl/reload_down_counter_timer_unit.sv
// Each result is registered in the result register, or in the skid on a stall.
// Throughput: one item per cycle while the skid is empty; the state update is a
// single pass of compare/decrement logic between timer and result registers.
// A two-entry output stage (result register plus skid) keeps input ready high
// while the skid is empty. Reset clears all timer state and both valid bits.
`include "reload_down_counter_timer_unit_macros.svh"

module reload_down_counter_timer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  rdct_in_if.sink      in_i,
  rdct_out_if.source   out_o
);
  import rdct_pkg::*;

  // timer state
  logic   core_clk_q;
  logic   en_q, en_d;
  logic   irq_en_q, irq_en_d;
  logic   one_shot_q, one_shot_d;
  logic   flag_q, flag_d;
  count_t reload_q, reload_d;
  count_t cur_q, cur_d;
  presc_t presc_q, presc_d;

  // output stage
  logic  out_vld_q, skid_vld_q;
  data_t rdata_q, skid_rdata_q;
  logic  irq_q, skid_irq_q;

  logic  in_fire, out_fire;
  data_t rdata;
  logic  irq;
  logic  count_evt;

  assign in_i.ready = !skid_vld_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_vld_q && out_o.ready;

  always_comb begin
    en_d       = en_q;
    irq_en_d   = irq_en_q;
    one_shot_d = one_shot_q;
    flag_d     = flag_q;
    reload_d   = reload_q;
    cur_d      = cur_q;
    presc_d    = presc_q;
    rdata      = '0;
    irq        = 1'b0;
    count_evt  = 1'b0;
    if (in_fire) begin
      case (in_i.action)
        ACT_TICK: begin
          if (en_q) begin
            if (core_clk_q) begin
              count_evt = 1'b1;
            end else begin
              presc_d   = presc_q + presc_t'(1);
              count_evt = (presc_q == '1);
            end
            if (count_evt) begin
              if (cur_q == '0) begin
                cur_d = reload_q;
              end else begin
                cur_d = cur_q - count_t'(1);
                if (cur_q == count_t'(1)) begin
                  flag_d = 1'b1;
                  if (irq_en_q) begin
                    irq = 1'b1;
                    // single-shot: stop and drop the reload
                    if (one_shot_q) begin
                      en_d     = 1'b0;
                      irq_en_d = 1'b0;
                      reload_d = '0;
                      cur_d    = '0;
                    end
                  end
                end
              end
            end
          end
        end
        ACT_READ: begin
          case (in_i.reg_index)
            REG_CTRL: begin
              rdata[CTRL_ENABLE_BIT]   = en_q;
              rdata[CTRL_IRQ_EN_BIT]   = irq_en_q;
              rdata[CTRL_CORE_CLK_BIT] = core_clk_q;
              rdata[CTRL_ONE_SHOT_BIT] = one_shot_q;
              rdata[CTRL_FLAG_BIT]     = flag_q;
              flag_d                   = 1'b0;
            end
            REG_RELOAD:  rdata = DATA_WIDTH'(reload_q);
            REG_CURRENT: rdata = DATA_WIDTH'(cur_q);
            REG_ELAPSED: rdata = DATA_WIDTH'(count_t'(reload_q - cur_q));
            default:     rdata = '0;
          endcase
        end
        ACT_WRITE: begin
          case (in_i.reg_index)
            REG_CTRL: begin
              en_d       = in_i.write_data[CTRL_ENABLE_BIT];
              irq_en_d   = in_i.write_data[CTRL_IRQ_EN_BIT];
              one_shot_d = in_i.write_data[CTRL_ONE_SHOT_BIT];
            end
            REG_RELOAD: reload_d = in_i.write_data[COUNTER_WIDTH-1:0];
            REG_CURRENT: begin
              cur_d  = '0;
              flag_d = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_clk_q <= 1'b0;
      en_q       <= 1'b0;
      irq_en_q   <= 1'b0;
      one_shot_q <= 1'b0;
      flag_q     <= 1'b0;
      reload_q   <= '0;
      cur_q      <= '0;
      presc_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        core_clk_q <= cfg_wdata_i;
      end
      en_q       <= en_d;
      irq_en_q   <= irq_en_d;
      one_shot_q <= one_shot_d;
      flag_q     <= flag_d;
      reload_q   <= reload_d;
      cur_q      <= cur_d;
      presc_q    <= presc_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_vld_q || out_fire) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_vld_q  <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (!out_vld_q || out_fire) begin
        rdata_q <= rdata;
        irq_q   <= irq;
      end else begin
        skid_rdata_q <= rdata;
        skid_irq_q   <= irq;
      end
    end else if (out_fire && skid_vld_q) begin
      rdata_q <= skid_rdata_q;
      irq_q   <= skid_irq_q;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.read_data         = rdata_q;
  assign out_o.interrupt_request = irq_q;

  `RDCT_ASSERT_ALWAYS(a_skid_behind_out, !rst_ni || !skid_vld_q || out_vld_q,
    "skid entry holds an item while the result register is empty")
  `RDCT_ASSERT(a_irq_sets_flag, (in_fire && irq) |=> flag_q,
    "interrupt raised without setting the count flag")
  `RDCT_ASSERT(a_one_shot_stop, (in_fire && irq && one_shot_q) |=> (!en_q && cur_q == '0),
    "single-shot interrupt did not stop the timer")
  `RDCT_ASSERT(a_idle_hold,
    (in_fire && in_i.action == ACT_TICK && !en_q) |=> ($stable(cur_q) && $stable(presc_q)),
    "disabled timer changed its count on a tick")

endmodule
